// ===== rtl/bcd_rtc_calendar_alarms_core_assert.svh =====
// ----------------------------------------------------------------------------
// RTC core assertion macros
// Shared property wrappers for the RTC core checker.
// ----------------------------------------------------------------------------
`ifndef BCD_RTC_CALENDAR_ALARMS_CORE_ASSERT_SVH
`define BCD_RTC_CALENDAR_ALARMS_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define RTCA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted (active low)
`define RTCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtca_pkg.sv =====
// ----------------------------------------------------------------------------
// RTC core package
// Types, address map, item codes and BCD helpers for the RTC core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtca_pkg;

    localparam int ADDR_W    = 7;
    localparam int DATA_W    = 8;
    localparam int TIME_REGS = 7;
    localparam int ALM_REGS  = 8;

    typedef logic [DATA_W-1:0]                 byte_t;
    typedef logic [TIME_REGS-1:0][DATA_W-1:0]  time_file_t;
    typedef logic [ALM_REGS-1:0][DATA_W-1:0]   alarm_file_t;
    typedef logic [3:0][DATA_W-1:0]            quad_t;

    // item codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // address map
    localparam logic [ADDR_W-1:0] ADDR_TIME_LAST = 7'h06;
    localparam logic [ADDR_W-1:0] ADDR_ALM0      = 7'h07;
    localparam logic [ADDR_W-1:0] ADDR_ALM0_LAST = 7'h0A;
    localparam logic [ADDR_W-1:0] ADDR_ALM1      = 7'h0B;
    localparam logic [ADDR_W-1:0] ADDR_ALM1_LAST = 7'h0E;
    localparam logic [ADDR_W-1:0] ADDR_CONTROL   = 7'h0F;
    localparam logic [ADDR_W-1:0] ADDR_STATUS    = 7'h10;
    localparam logic [ADDR_W-1:0] ADDR_TRICKLE   = 7'h11;
    localparam logic [ADDR_W-1:0] ADDR_RSVD      = 7'h12;
    localparam logic [ADDR_W-1:0] ADDR_RSVD_LAST = 7'h1F;
    localparam logic [ADDR_W-1:0] ADDR_RAM       = 7'h20;

    // control register bits
    localparam int CTL_NEOSC = 7;
    localparam int CTL_INTCN = 2;
    localparam int CTL_AIE1  = 1;
    localparam int CTL_AIE0  = 0;

    localparam byte_t CONTROL_RESET = 8'hC0;
    localparam byte_t HOUR_12_WRAP  = 8'h52;  // 12 AM in 12-hour mode

    // alarm mask patterns {day, hour, min, sec}
    localparam logic [3:0] MASK_EVERY_SEC = 4'hF;
    localparam logic [3:0] MASK_SEC       = 4'hE;
    localparam logic [3:0] MASK_MIN_SEC   = 4'hC;
    localparam logic [3:0] MASK_HMS       = 4'h8;
    localparam logic [3:0] MASK_DHMS      = 4'h0;

    typedef struct packed {
        time_file_t tm;
        logic       hit0;
        logic       hit1;
    } tick_res_t;

    function automatic logic bcd_ok(input byte_t v, input byte_t lo, input byte_t hi);
        return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9) && (v >= lo) && (v <= hi);
    endfunction

    function automatic byte_t bcd_next(input byte_t v);
        return (v[3:0] == 4'd9) ? {v[7:4] + 4'd1, 4'd0} : v + 8'd1;
    endfunction

    // seconds / minutes step; zero result means carry
    function automatic byte_t step_sixty(input byte_t v);
        return (!bcd_ok(v, 8'h00, 8'h59) || v == 8'h59) ? 8'h00 : bcd_next(v);
    endfunction

    // BCD year divisible by four
    function automatic logic leap_bcd(input byte_t yr);
        logic [3:0] u;
        u = yr[3:0];
        if (yr[4]) begin
            return (u == 4'd2) || (u == 4'd6);
        end
        return (u == 4'd0) || (u == 4'd4) || (u == 4'd8);
    endfunction

    // last day of a valid BCD month
    function automatic byte_t month_last(input byte_t mo, input logic leap);
        byte_t d;
        unique case (mo)
            8'h02:                      d = leap ? 8'h29 : 8'h28;
            8'h04, 8'h06, 8'h09, 8'h11: d = 8'h30;
            default:                    d = 8'h31;
        endcase
        return d;
    endfunction

    function automatic logic alarm_hit(input quad_t al, input quad_t tq);
        logic [3:0] m;
        logic [3:0] eq;
        logic       hit;
        for (int i = 0; i < 4; i++) begin
            m[i]  = al[i][7];
            eq[i] = (al[i][6:0] == tq[i][6:0]);
        end
        unique case (m)
            MASK_EVERY_SEC: hit = 1'b1;
            MASK_SEC:       hit = eq[0];
            MASK_MIN_SEC:   hit = &eq[1:0];
            MASK_HMS:       hit = &eq[2:0];
            MASK_DHMS:      hit = &eq;
            default:        hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bcd_rtc_calendar_alarms_core.sv =====
// ----------------------------------------------------------------------------
// BCD real-time clock / calendar core with two alarms
// Register block: one-second ticks, register reads and writes, user RAM.
// ----------------------------------------------------------------------------
//  channel | ports                                          | role
//  --------+------------------------------------------------+-------------------
//  s_      | s_valid s_ready s_mode s_address s_write_data  | tick / read / write
//  m_      | m_valid m_ready m_read_data m_int0_n m_int1_n  | one result per beat
//          | m_alarm0_flag m_alarm1_flag                    |
//
//  One beat per cycle sustained while m_ready drains the result register. A beat is accepted, its effect on the clock,
//  alarm and control state is computed in the same cycle and stored at the
//  accepting edge; the result shows on m_ the next cycle.
//  The RAM read port is registered, so RAM read data joins the result there.
//  s_ready is high whenever the result register is empty or being drained.
//  Synchronous active-low reset; no RAM clearing pass (per-byte valid bits).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_rtc_calendar_alarms_core #(
    parameter int RAM_BYTES = 96
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [6:0] s_address,
    input  logic [7:0] s_write_data,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_int0_n,
    output logic       m_int1_n,
    output logic       m_alarm0_flag,
    output logic       m_alarm1_flag
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    // architectural state
    rtca_pkg::time_file_t  time_reg,    time_next;
    rtca_pkg::alarm_file_t alarm_reg,   alarm_next;
    rtca_pkg::byte_t       control_reg, control_next;
    rtca_pkg::byte_t       trickle_reg, trickle_next;
    logic [1:0]            flags_reg,   flags_next;   // bit0 alarm 0, bit1 alarm 1
    logic [1:0]            pins_reg,    pins_next;    // bit0 int0_n, bit1 int1_n

    // user RAM, valid bit per byte stands in for the reset clear
    rtca_pkg::byte_t       ram [RAM_BYTES];
    logic [RAM_BYTES-1:0]  ram_valid_reg;
    rtca_pkg::byte_t       ram_q_reg;
    logic                  ram_q_valid_reg;

    // result register
    logic                  res_valid_reg;
    rtca_pkg::byte_t       res_data_reg,   res_data_next;
    logic                  res_is_ram_reg, res_is_ram_next;

    rtca_pkg::tick_res_t   tk;
    logic                  acc;
    logic                  ram_hit;
    logic [6:0]            ram_off;
    logic [RAM_AW-1:0]     ram_idx;
    logic [6:0]            alm_off;
    logic                  ram_we;
    logic                  intcn;

    assign acc     = s_valid && s_ready;
    assign s_ready = !res_valid_reg || m_ready;

    assign ram_off = s_address - rtca_pkg::ADDR_RAM;
    assign ram_hit = (s_address >= rtca_pkg::ADDR_RAM) && (ram_off < RAM_BYTES);
    assign ram_idx = ram_off[RAM_AW-1:0];
    assign alm_off = s_address - rtca_pkg::ADDR_ALM0;
    assign ram_we  = acc && (s_mode == rtca_pkg::MODE_WRITE) && ram_hit;

    rtca_tick u_tick (
        .tm_cur (time_reg),
        .alm    (alarm_reg),
        .res    (tk)
    );

    // next state for the beat at the inputs
    always_comb begin
        time_next       = time_reg;
        alarm_next      = alarm_reg;
        control_next    = control_reg;
        trickle_next    = trickle_reg;
        flags_next      = flags_reg;
        pins_next       = pins_reg;
        res_data_next   = 8'h00;
        res_is_ram_next = 1'b0;
        intcn           = control_reg[rtca_pkg::CTL_INTCN];

        unique case (s_mode)
            rtca_pkg::MODE_TICK: begin
                if (!control_reg[rtca_pkg::CTL_NEOSC]) begin
                    time_next = tk.tm;
                    if (tk.hit0) begin
                        flags_next[0] = 1'b1;
                        if (control_reg[rtca_pkg::CTL_AIE0]) begin
                            pins_next[0] = 1'b0;
                        end
                    end
                    if (tk.hit1) begin
                        flags_next[1] = 1'b1;
                        if (control_reg[rtca_pkg::CTL_AIE1]) begin
                            // INTCN routes alarm 1 to its own pin
                            if (intcn) begin
                                pins_next[1] = 1'b0;
                            end else begin
                                pins_next[0] = 1'b0;
                            end
                        end
                    end
                end
            end
            rtca_pkg::MODE_READ, rtca_pkg::MODE_WRITE: begin
                if (s_mode == rtca_pkg::MODE_READ) begin
                    priority if (s_address <= rtca_pkg::ADDR_TIME_LAST) begin
                        res_data_next = time_reg[s_address[2:0]];
                    end else if (s_address <= rtca_pkg::ADDR_ALM1_LAST) begin
                        res_data_next = alarm_reg[alm_off[2:0]];
                    end else if (s_address == rtca_pkg::ADDR_CONTROL) begin
                        res_data_next = control_reg;
                    end else if (s_address == rtca_pkg::ADDR_STATUS) begin
                        res_data_next = {6'b000000, flags_reg};
                    end else if (s_address == rtca_pkg::ADDR_TRICKLE) begin
                        res_data_next = trickle_reg;
                    end else begin
                        res_is_ram_next = ram_hit;  // reserved reads stay 0
                    end
                end else begin
                    priority if (s_address <= rtca_pkg::ADDR_TIME_LAST) begin
                        time_next[s_address[2:0]] = s_write_data;
                    end else if (s_address <= rtca_pkg::ADDR_ALM1_LAST) begin
                        alarm_next[alm_off[2:0]] = s_write_data;
                    end else if (s_address == rtca_pkg::ADDR_CONTROL) begin
                        control_next = s_write_data;
                    end else if (s_address == rtca_pkg::ADDR_STATUS) begin
                        flags_next = s_write_data[1:0];
                    end else if (s_address == rtca_pkg::ADDR_TRICKLE) begin
                        trickle_next = s_write_data;
                    end else begin
                        // RAM handled by the memory block; reserved ignored
                    end
                end

                // any access to an alarm's registers clears its flag
                if (s_address >= rtca_pkg::ADDR_ALM0 && s_address <= rtca_pkg::ADDR_ALM0_LAST) begin
                    flags_next[0] = 1'b0;
                    if (intcn || !flags_next[1]) begin
                        pins_next[0] = 1'b1;
                    end
                end else if (s_address >= rtca_pkg::ADDR_ALM1
                             && s_address <= rtca_pkg::ADDR_ALM1_LAST) begin
                    flags_next[1] = 1'b0;
                    if (intcn) begin
                        pins_next[1] = 1'b1;
                    end else if (!flags_next[0]) begin
                        pins_next[0] = 1'b1;
                    end
                end
            end
            default: begin
                // unused code: no effect, reads 0
            end
        endcase
    end

    // control / architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg      <= '0;
            alarm_reg     <= '0;
            control_reg   <= rtca_pkg::CONTROL_RESET;
            trickle_reg   <= 8'h00;
            flags_reg     <= 2'b00;
            pins_reg      <= 2'b11;
            ram_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (acc) begin
                time_reg    <= time_next;
                alarm_reg   <= alarm_next;
                control_reg <= control_next;
                trickle_reg <= trickle_next;
                flags_reg   <= flags_next;
                pins_reg    <= pins_next;
            end
            if (ram_we) begin
                ram_valid_reg[ram_idx] <= 1'b1;
            end
            if (acc) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (acc) begin
            res_data_reg    <= res_data_next;
            res_is_ram_reg  <= res_is_ram_next;
            ram_q_valid_reg <= ram_valid_reg[ram_idx];
        end
    end

    // user RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram[ram_idx] <= s_write_data;
        end
        if (acc) begin
            ram_q_reg <= ram[ram_idx];
        end
    end

    // Flags and pins are read straight from state: state only moves on an
    // accept, and an accept also loads the result register with that beat.
    assign m_valid       = res_valid_reg;
    assign m_read_data   = res_is_ram_reg ? (ram_q_valid_reg ? ram_q_reg : 8'h00)
                                          : res_data_reg;
    assign m_int0_n      = pins_reg[0];
    assign m_int1_n      = pins_reg[1];
    assign m_alarm0_flag = flags_reg[0];
    assign m_alarm1_flag = flags_reg[1];

endmodule

`default_nettype wire

// ===== rtl/rtca_tick.sv =====
// ----------------------------------------------------------------------------
// RTC one-second step
// Next BCD time/calendar for one tick and the two alarm matches on it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtca_tick (
    input  rtca_pkg::time_file_t  tm_cur,
    input  rtca_pkg::alarm_file_t alm,
    output rtca_pkg::tick_res_t   res
);

    rtca_pkg::time_file_t tm_n;
    rtca_pkg::byte_t      sec_n, min_n, hr_n, hr12, h;
    rtca_pkg::byte_t      yr, mo, dt, last;
    logic                 c_sec, c_min, c_hr, hr_carry, pm, cal_ok;

    always_comb begin
        tm_n = tm_cur;

        sec_n   = rtca_pkg::step_sixty(tm_cur[0]);
        c_sec   = (sec_n == 8'h00);
        tm_n[0] = sec_n;

        min_n = rtca_pkg::step_sixty(tm_cur[1]);
        c_min = c_sec && (min_n == 8'h00);
        if (c_sec) begin
            tm_n[1] = min_n;
        end

        // hours: 12-hour (bit 6) or 24-hour
        h    = tm_cur[2];
        pm   = h[5];
        hr12 = {3'b000, h[4:0]};
        if (h[6]) begin
            if (!rtca_pkg::bcd_ok(hr12, 8'h01, 8'h12)) begin
                hr_n = 8'h00;
            end else if (hr12 == 8'h11) begin
                hr_n = {2'b01, ~pm, 5'h12};
            end else if (hr12 == 8'h12) begin
                hr_n = {2'b01, pm, 5'h01};
            end else begin
                hr_n = {2'b01, pm, 5'h00} | rtca_pkg::bcd_next(hr12);
            end
            hr_carry = (hr_n == rtca_pkg::HOUR_12_WRAP);
        end else begin
            hr_n     = (!rtca_pkg::bcd_ok(h, 8'h00, 8'h23) || h == 8'h23) ? 8'h00
                                                                          : rtca_pkg::bcd_next(h);
            hr_carry = (hr_n == 8'h00);
        end
        c_hr = c_min && hr_carry;
        if (c_min) begin
            tm_n[2] = hr_n;
        end

        // calendar
        yr     = tm_cur[6];
        mo     = {2'b00, tm_cur[5][5:0]};
        dt     = {2'b00, tm_cur[4][5:0]};
        last   = rtca_pkg::month_last(mo, rtca_pkg::leap_bcd(yr));
        cal_ok = rtca_pkg::bcd_ok(yr, 8'h00, 8'h99) && rtca_pkg::bcd_ok(mo, 8'h01, 8'h12)
              && rtca_pkg::bcd_ok(dt, 8'h01, 8'h31) && (dt <= last);
        if (c_hr) begin
            tm_n[3] = (tm_cur[3] == 8'h07) ? 8'h01 : tm_cur[3] + 8'd1;
            if (!cal_ok) begin
                tm_n[4] = 8'h01;
                tm_n[5] = 8'h01;
                tm_n[6] = 8'h00;
            end else if (dt != last) begin
                tm_n[4] = rtca_pkg::bcd_next(dt);
                tm_n[5] = mo;
                tm_n[6] = yr;
            end else begin
                tm_n[4] = 8'h01;
                if (mo != 8'h12) begin
                    tm_n[5] = rtca_pkg::bcd_next(mo);
                    tm_n[6] = yr;
                end else begin
                    tm_n[5] = 8'h01;
                    tm_n[6] = (yr == 8'h99) ? 8'h00 : rtca_pkg::bcd_next(yr);
                end
            end
        end

        res.tm   = tm_n;
        res.hit0 = rtca_pkg::alarm_hit(alm[3:0], tm_n[3:0]);
        res.hit1 = rtca_pkg::alarm_hit(alm[7:4], tm_n[3:0]);
    end

endmodule

`default_nettype wire

// ===== rtl/rtca_checker.sv =====
// ----------------------------------------------------------------------------
// RTC core port checker
// Port-level checks on result timing and register decode, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bcd_rtc_calendar_alarms_core_assert.svh"

module rtca_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_mode,
    input logic [6:0] s_address,
    input logic [7:0] s_write_data,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_int0_n,
    input logic       m_int1_n,
    input logic       m_alarm0_flag,
    input logic       m_alarm1_flag
);

    logic acc;
    assign acc = s_valid && s_ready;

    // stalled result beat holds
    `RTCA_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_int0_n) && $stable(m_int1_n) && $stable(m_alarm0_flag) && $stable(m_alarm1_flag), "result changed while stalled")

    // status write shows up in the flags of its own result
    `RTCA_ASSERT_NEXT(a_status_wr, aclk, aresetn, acc && s_mode == rtca_pkg::MODE_WRITE && s_address == rtca_pkg::ADDR_STATUS, m_valid && m_alarm0_flag == $past(s_write_data[0]) && m_alarm1_flag == $past(s_write_data[1]), "status write not reflected")

    // ticks, writes and unused-code beats return zero data
    `RTCA_ASSERT_NEXT(a_nonread_zero, aclk, aresetn, acc && s_mode != rtca_pkg::MODE_READ, m_valid && m_read_data == 8'h00, "non-read beat returned data")

    // reserved addresses read zero
    `RTCA_ASSERT_NEXT(a_rsvd_zero, aclk, aresetn, acc && s_mode == rtca_pkg::MODE_READ && s_address >= rtca_pkg::ADDR_RSVD && s_address <= rtca_pkg::ADDR_RSVD_LAST, m_read_data == 8'h00, "reserved address read nonzero")

endmodule

bind bcd_rtc_calendar_alarms_core rtca_checker u_rtca_checker (.*);

`default_nettype wire
